FILE: rtl/core/iorw_pkg.sv
// Shared types and constants of the IRQ override redirection writer.
// No dependencies; used by iorw_table, iorw_search and the top level.
package iorw_pkg;

   // Input beat kinds.
   localparam logic KIND_LOAD  = 1'b0;
   localparam logic KIND_REMAP = 1'b1;

   // Configuration register indexes.
   localparam logic CSR_OVERRIDE_COUNT = 1'b0;
   localparam logic CSR_GSI_BASE       = 1'b1;

   // The legacy IRQ that is always level triggered on an override hit.
   localparam logic [7:0] IRQ_FORCED_LEVEL = 8'd11;

   // Redirection table register select of entry 0.
   localparam logic [7:0] REG_INDEX_BASE = 8'h10;

   // Override flag bits.
   localparam int FLAG_POL_BIT   = 1;
   localparam int FLAG_LEVEL_BIT = 3;

   // Redirection entry low word bits.
   localparam int WORD_POL_BIT  = 13;
   localparam int WORD_TRIG_BIT = 15;
   localparam int WORD_MASK_BIT = 16;

   // One override table entry. Only the low byte of the GSI is kept, since
   // only that byte reaches the register index.
   typedef struct packed {
      logic [7:0] irq;
      logic [7:0] gsi;
      logic       low_active;
      logic       level;
   } entry_type;

   // Outcome of one table search.
   typedef struct packed {
      logic       done;
      logic [7:0] gsi;
      logic       low_active;
      logic       level;
   } search_res_type;

   // Sequencer states of the search unit.
   typedef enum logic [1:0] {
      S_IDLE = 2'b01,
      S_SCAN = 2'b10
   } search_state_type;

   // Builds the low word of a redirection entry.
   function automatic logic [31:0] build_low_word(input logic [7:0] vector,
                                                  input logic       low_active,
                                                  input logic       level,
                                                  input logic       masked);
      logic [31:0] word;
      word                = 32'd0;
      word[7:0]           = vector;
      word[WORD_POL_BIT]  = low_active;
      word[WORD_TRIG_BIT] = level;
      word[WORD_MASK_BIT] = masked;
      return word;
   endfunction

endpackage

FILE: rtl/core/iorw_table.sv
// Override table memory: one write port, one registered read port.
// Depends on iorw_pkg for the entry type.
module iorw_table #(
   parameter int DEPTH = 16,
   parameter int AW    = 4
) (
   input  logic                clock,
   input  logic                wr_en,
   input  logic [AW-1:0]       wr_addr,
   input  iorw_pkg::entry_type wr_data,
   input  logic                rd_en,
   input  logic [AW-1:0]       rd_addr,
   output iorw_pkg::entry_type rd_data
);
   import iorw_pkg::*;

   entry_type mem [DEPTH];
   entry_type rd_data_ff;

   // Entries hold no reset value; the search must read only loaded entries, which the block itself does not enforce.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/core/iorw_search.sv
// Search sequencer: walks the override table one entry per cycle through a
// single compare and subtract unit. Depends on iorw_pkg.
module iorw_search #(
   parameter int MAX_OVERRIDES = 16,
   parameter int AW            = 4,
   parameter int CW            = 5
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  logic [7:0]               irq,
   input  logic [4:0]               override_count,
   input  logic [7:0]               gsi_base,
   output logic                     rd_en,
   output logic [AW-1:0]            rd_addr,
   input  iorw_pkg::entry_type      rd_data,
   output iorw_pkg::search_res_type result
);
   import iorw_pkg::*;

   search_state_type state_ff, state_in;
   logic [CW-1:0]    idx_ff, idx_in;
   logic [CW-1:0]    limit_ff, limit_in;
   logic             chk_ff, chk_in;
   search_res_type   result_ff, result_in;
   logic             issue;
   logic             match;

   // Entries beyond the table depth are never searched.
   always_comb begin
      if (32'(override_count) > MAX_OVERRIDES) begin
         limit_in = CW'(MAX_OVERRIDES);
      end else begin
         limit_in = CW'(override_count);
      end
   end

   // The compare sees the read data in the cycle after its address is issued.
   assign issue   = (state_ff == S_SCAN) && (idx_ff < limit_ff);
   assign rd_en   = issue;
   assign rd_addr = idx_ff[AW-1:0];
   assign match   = chk_ff && (rd_data.irq == irq);

   // Sequencer and the shared compare and subtract unit.
   always_comb begin
      state_in  = state_ff;
      idx_in    = idx_ff;
      chk_in    = 1'b0;
      result_in = result_ff;
      result_in.done = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               idx_in   = '0;
               state_in = S_SCAN;
            end
         end
         S_SCAN: begin
            chk_in = issue;
            if (issue) begin
               idx_in = CW'(idx_ff + 1'b1);
            end
            if (match) begin
               // First hit in table order wins.
               result_in.done       = 1'b1;
               result_in.gsi        = 8'(rd_data.gsi - gsi_base);
               result_in.low_active = rd_data.low_active;
               result_in.level      = (irq == IRQ_FORCED_LEVEL) ? 1'b1 : rd_data.level;
               chk_in               = 1'b0;
               state_in             = S_IDLE;
            end else if (!issue && !chk_ff) begin
               // No entry left: identity mapping, active high, edge.
               result_in.done       = 1'b1;
               result_in.gsi        = irq;
               result_in.low_active = 1'b0;
               result_in.level      = 1'b0;
               state_in             = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Control state resets; the datapath fields do not.
   always_ff @(posedge clock) begin
      idx_ff               <= idx_in;
      result_ff.gsi        <= result_in.gsi;
      result_ff.low_active <= result_in.low_active;
      result_ff.level      <= result_in.level;
      if (start) begin
         limit_ff <= limit_in;
      end
      if (reset) begin
         state_ff       <= S_IDLE;
         chk_ff         <= 1'b0;
         result_ff.done <= 1'b0;
      end else begin
         state_ff       <= state_in;
         chk_ff         <= chk_in;
         result_ff.done <= result_in.done;
      end
   end

   assign result = result_ff;

endmodule

FILE: rtl/core/irq_override_redirection_writer_unit.sv
// Top level of the IRQ override redirection writer: input and result
// channels, configuration registers. Depends on iorw_pkg, iorw_table, iorw_search.
//
//   channel  direction  handshake             payload
//   req      in         req_valid/req_stall   kind slot irq entry_gsi entry_flags vector masked
//   rsp      out        rsp_valid/rsp_stall   reg_index reg_data last
//   csr      in         csr_wr_en             csr_index csr_wr_data
//
// A load beat writes the table directly. A remap beat reads the entries in table order
// through the single table port until the first hit, or for a miss until all m are read,
// m being the smaller of override_count and MAX_OVERRIDES; two result beats follow.
// Reset clears control state only; table entries are undefined until loaded.
// req_stall is high while a search runs or a result beat waits; rsp_stall holds a beat.
module irq_override_redirection_writer_unit #(
   parameter int MAX_OVERRIDES = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_kind,
   input  logic [3:0]  req_slot,
   input  logic [7:0]  req_irq,
   input  logic [31:0] req_entry_gsi,
   input  logic [15:0] req_entry_flags,
   input  logic [7:0]  req_vector,
   input  logic        req_masked,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_reg_index,
   output logic [31:0] rsp_reg_data,
   output logic        rsp_last,
   input  logic        csr_wr_en,
   input  logic        csr_index,
   input  logic [31:0] csr_wr_data
);
   import iorw_pkg::*;

   localparam int AW = (MAX_OVERRIDES > 1) ? $clog2(MAX_OVERRIDES) : 1;
   localparam int CW = $clog2(MAX_OVERRIDES + 1);

   logic [4:0]     override_count_ff;
   logic [7:0]     gsi_base_ff;
   logic           busy_ff;
   logic [7:0]     irq_ff;
   logic [7:0]     vector_ff;
   logic           masked_ff;
   logic           rsp_valid_ff;
   logic           rsp_last_ff;
   logic [7:0]     rsp_reg_index_ff;
   logic [31:0]    rsp_reg_data_ff;
   logic           req_accept;
   logic           rsp_accept;
   logic           start;
   logic           tbl_wr_en;
   logic [AW-1:0]  tbl_wr_addr;
   entry_type      tbl_wr_data;
   logic           tbl_rd_en;
   logic [AW-1:0]  tbl_rd_addr;
   entry_type      tbl_rd_data;
   search_res_type search_res;

   assign req_stall  = busy_ff || rsp_valid_ff;
   assign req_accept = req_valid && !req_stall;
   assign rsp_accept = rsp_valid_ff && !rsp_stall;
   assign start      = req_accept && (req_kind == KIND_REMAP);

   // Configuration registers. Only the low byte of gsi_base reaches the index.
   always_ff @(posedge clock) begin
      if (reset) begin
         override_count_ff <= 5'd0;
         gsi_base_ff       <= 8'd0;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_OVERRIDE_COUNT: override_count_ff <= csr_wr_data[4:0];
            CSR_GSI_BASE:       gsi_base_ff       <= csr_wr_data[7:0];
            default:            ;
         endcase
      end
   end

   // Load beats write the table directly; slots past the depth are dropped.
   assign tbl_wr_en              = req_accept && (req_kind == KIND_LOAD)
                                   && (32'(req_slot) < MAX_OVERRIDES);
   assign tbl_wr_addr            = AW'(req_slot);
   assign tbl_wr_data.irq        = req_irq;
   assign tbl_wr_data.gsi        = req_entry_gsi[7:0];
   assign tbl_wr_data.low_active = req_entry_flags[FLAG_POL_BIT];
   assign tbl_wr_data.level      = req_entry_flags[FLAG_LEVEL_BIT];

   iorw_table #(
      .DEPTH (MAX_OVERRIDES),
      .AW    (AW)
   ) u_table (
      .clock   (clock),
      .wr_en   (tbl_wr_en),
      .wr_addr (tbl_wr_addr),
      .wr_data (tbl_wr_data),
      .rd_en   (tbl_rd_en),
      .rd_addr (tbl_rd_addr),
      .rd_data (tbl_rd_data)
   );

   iorw_search #(
      .MAX_OVERRIDES (MAX_OVERRIDES),
      .AW            (AW),
      .CW            (CW)
   ) u_search (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .irq            (irq_ff),
      .override_count (override_count_ff),
      .gsi_base       (gsi_base_ff),
      .rd_en          (tbl_rd_en),
      .rd_addr        (tbl_rd_addr),
      .rd_data        (tbl_rd_data),
      .result         (search_res)
   );

   // Remap payload held for the search and the first beat.
   always_ff @(posedge clock) begin
      if (start) begin
         irq_ff    <= req_irq;
         vector_ff <= req_vector;
         masked_ff <= req_masked;
      end
   end

   // Busy from remap accept until the search reports.
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else if (start) begin
         busy_ff <= 1'b1;
      end else if (search_res.done) begin
         busy_ff <= 1'b0;
      end
   end

   // Result register: low word beat, then the zero high word beat.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (search_res.done) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_accept && rsp_last_ff) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (search_res.done) begin
         rsp_last_ff      <= 1'b0;
         rsp_reg_index_ff <= 8'(REG_INDEX_BASE + {search_res.gsi[6:0], 1'b0});
         rsp_reg_data_ff  <= build_low_word(vector_ff, search_res.low_active,
                                            search_res.level, masked_ff);
      end else if (rsp_accept && !rsp_last_ff) begin
         rsp_last_ff      <= 1'b1;
         rsp_reg_index_ff <= 8'(rsp_reg_index_ff + 8'd1);
         rsp_reg_data_ff  <= 32'd0;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_last      = rsp_last_ff;
   assign rsp_reg_index = rsp_reg_index_ff;
   assign rsp_reg_data  = rsp_reg_data_ff;

`ifndef NO_ASSERTIONS
   // A search never overlaps pending result beats.
   a_busy_excl: assert property (@(posedge clock) disable iff (reset)
      !(busy_ff && rsp_valid_ff))
      else $error("search running while result beats pending");

   // A finished search presents the first beat next cycle.
   a_first_beat: assert property (@(posedge clock) disable iff (reset)
      search_res.done |=> (rsp_valid_ff && !rsp_last_ff))
      else $error("search result not presented as first beat");

   // The final beat leaves the channel empty once taken.
   a_last_drains: assert property (@(posedge clock) disable iff (reset)
      (rsp_accept && rsp_last_ff) |=> !rsp_valid_ff)
      else $error("result channel not empty after final beat");

   // The second beat follows the first at the next register index.
   a_index_step: assert property (@(posedge clock) disable iff (reset)
      (rsp_accept && !rsp_last_ff) |=> (rsp_reg_index_ff == 8'($past(rsp_reg_index_ff) + 8'd1)))
      else $error("second beat index mismatch");
`endif

endmodule

FILE: sim/tb_irq_override_redirection_writer_unit.sv
`timescale 1ns / 100ps
// Self-checking testbench of irq_override_redirection_writer_unit: directed and random
// load and remap beats, with every redirection register write predicted and compared.
// Depends on iorw_pkg and the RTL of the unit.
module tb_irq_override_redirection_writer_unit;
   import iorw_pkg::*;

   localparam int TABLE_DEPTH     = 16;
   localparam int CLOCK_PERIOD    = 10;
   localparam int RANDOM_BEATS    = 1700;
   localparam int PHASES          = 12;
   localparam int SETTLE_CYCLES   = 40;
   localparam int CYCLE_LIMIT     = 2000000;
   localparam int PRESSURE_AT     = 500;
   localparam int PRESSURE_CYCLES = 400;

   // One input beat, field for field.
   typedef struct packed {
      logic        kind;
      logic [3:0]  slot;
      logic [7:0]  irq;
      logic [31:0] entry_gsi;
      logic [15:0] entry_flags;
      logic [7:0]  vector;
      logic        masked;
   } req_beat_t;

   // One redirection register write as it leaves the unit.
   typedef struct packed {
      logic [7:0]  reg_index;
      logic [31:0] reg_data;
      logic        last;
   } reg_write_t;

   // Shadow of the override table and registers, plus the writes still owed.
   class remap_scoreboard;
      logic [7:0]  src_irq [TABLE_DEPTH];
      logic [31:0] dst_gsi [TABLE_DEPTH];
      logic        low_active [TABLE_DEPTH];
      logic        level [TABLE_DEPTH];
      logic [4:0]  override_count;
      logic [31:0] gsi_base;
      reg_write_t  expected_writes [$];
      int          errors;

      function new();
         override_count = 5'd0;
         gsi_base       = 32'd0;
         errors         = 0;
      endfunction

      function void write_reg(input logic idx, input logic [31:0] data);
         if (idx == CSR_OVERRIDE_COUNT) override_count = data[4:0];
         else gsi_base = data;
      endfunction

      function int pending();
         return expected_writes.size();
      endfunction

      // A load fills one entry; a remap searches and owes two register writes.
      function void note_request(input req_beat_t b);
         int          depth;
         int          i;
         logic        hit;
         logic [31:0] gsi;
         logic        pol;
         logic        trig;
         logic [7:0]  index;
         reg_write_t  w;
         if (b.kind == KIND_LOAD) begin
            src_irq[b.slot]    = b.irq;
            dst_gsi[b.slot]    = b.entry_gsi;
            low_active[b.slot] = b.entry_flags[FLAG_POL_BIT];
            level[b.slot]      = b.entry_flags[FLAG_LEVEL_BIT];
            return;
         end
         depth = (override_count > TABLE_DEPTH) ? TABLE_DEPTH : override_count;
         hit   = 1'b0;
         gsi   = 32'(b.irq);
         pol   = 1'b0;
         trig  = 1'b0;
         // The first matching entry wins; a miss keeps the identity mapping.
         for (i = 0; i < depth; i++) begin
            if (!hit && src_irq[i] == b.irq) begin
               hit  = 1'b1;
               gsi  = dst_gsi[i] - gsi_base;
               pol  = low_active[i];
               trig = (b.irq == IRQ_FORCED_LEVEL) ? 1'b1 : level[i];
            end
         end
         index = REG_INDEX_BASE + {gsi[6:0], 1'b0};
         w.reg_index = index;
         w.reg_data  = 32'(b.vector) | (32'(pol) << WORD_POL_BIT) |
                       (32'(trig) << WORD_TRIG_BIT) | (32'(b.masked) << WORD_MASK_BIT);
         w.last      = 1'b0;
         expected_writes.push_back(w);
         w.reg_index = index + 8'd1;
         w.reg_data  = 32'd0;
         w.last      = 1'b1;
         expected_writes.push_back(w);
      endfunction

      task report_mismatch(input string what);
         errors++;
         $display("[%0t] mismatch: %s", $time, what);
      endtask

      task check_write(input logic [7:0] idx, input logic [31:0] data, input logic last);
         reg_write_t w;
         if (expected_writes.size() == 0) begin
            report_mismatch($sformatf("write %02h <= %08h last %0b with none expected",
                                      idx, data, last));
            return;
         end
         w = expected_writes.pop_front();
         if (idx !== w.reg_index)
            report_mismatch($sformatf("reg_index %02h, expected %02h", idx, w.reg_index));
         if (data !== w.reg_data)
            report_mismatch($sformatf("reg_data %08h, expected %08h at index %02h",
                                      data, w.reg_data, w.reg_index));
         if (last !== w.last)
            report_mismatch($sformatf("last %0b, expected %0b at index %02h",
                                      last, w.last, w.reg_index));
      endtask
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic        req_kind = KIND_LOAD;
   logic [3:0]  req_slot = 4'd0;
   logic [7:0]  req_irq = 8'd0;
   logic [31:0] req_entry_gsi = 32'd0;
   logic [15:0] req_entry_flags = 16'd0;
   logic [7:0]  req_vector = 8'd0;
   logic        req_masked = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [7:0]  rsp_reg_index;
   logic [31:0] rsp_reg_data;
   logic        rsp_last;
   logic        csr_wr_en = 1'b0;
   logic        csr_index = CSR_OVERRIDE_COUNT;
   logic [31:0] csr_wr_data = 32'd0;

   remap_scoreboard sb;
   int  requests_sent = 0;
   int  cycle_count = 0;
   int  hold_left = 0;
   int  run_left = 0;
   bit  pressure_done = 1'b0;

   irq_override_redirection_writer_unit #(
      .MAX_OVERRIDES(TABLE_DEPTH)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_kind(req_kind),
      .req_slot(req_slot),
      .req_irq(req_irq),
      .req_entry_gsi(req_entry_gsi),
      .req_entry_flags(req_entry_flags),
      .req_vector(req_vector),
      .req_masked(req_masked),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_reg_index(rsp_reg_index),
      .rsp_reg_data(rsp_reg_data),
      .rsp_last(rsp_last),
      .csr_wr_en(csr_wr_en),
      .csr_index(csr_index),
      .csr_wr_data(csr_wr_data)
   );

   always #(CLOCK_PERIOD / 2) clock = ~clock;

   // Run limit in case the unit hangs.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("irq_override_redirection_writer_unit verification failed");
         $finish;
      end
   end

   // Every accepted result beat goes to the scoreboard.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         sb.check_write(rsp_reg_index, rsp_reg_data, rsp_last);
   end

   // Receiver back-pressure: alternating runs, mostly short, and one long hold-off
   // partway through so that the unit backs up into its input.
   always @(posedge clock) begin
      if (!reset) begin
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else if (!pressure_done && requests_sent >= PRESSURE_AT) begin
            pressure_done = 1'b1;
            hold_left     = PRESSURE_CYCLES;
            rsp_stall <= 1'b1;
         end else if (run_left > 0) begin
            run_left--;
         end else if (rsp_stall) begin
            rsp_stall <= 1'b0;
            run_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 80)
                                                   : $urandom_range(0, 4);
         end else begin
            rsp_stall <= 1'b1;
            run_left = ($urandom_range(0, 9) == 0) ? $urandom_range(15, 60)
                                                   : $urandom_range(0, 2);
         end
      end
   end

   function automatic req_beat_t make_request(input logic        kind,
                                              input logic [3:0]  slot,
                                              input logic [7:0]  irq,
                                              input logic [31:0] gsi,
                                              input logic [15:0] flags,
                                              input logic [7:0]  vector,
                                              input logic        masked);
      req_beat_t b;
      b.kind        = kind;
      b.slot        = slot;
      b.irq         = irq;
      b.entry_gsi   = gsi;
      b.entry_flags = flags;
      b.vector      = vector;
      b.masked      = masked;
      return b;
   endfunction

   // Offers one beat and holds it until the unit takes it.
   task automatic send_request(input req_beat_t b);
      req_valid       <= 1'b1;
      req_kind        <= b.kind;
      req_slot        <= b.slot;
      req_irq         <= b.irq;
      req_entry_gsi   <= b.entry_gsi;
      req_entry_flags <= b.entry_flags;
      req_vector      <= b.vector;
      req_masked      <= b.masked;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sb.note_request(b);
      requests_sent++;
   endtask

   task automatic pause_requests(input int cycles);
      if (cycles > 0) begin
         req_valid <= 1'b0;
         repeat (cycles) @(posedge clock);
      end
   endtask

   // Drains all owed writes, then lets a trailing load or search finish.
   task automatic wait_idle();
      req_valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_settings(input logic [31:0] count_word, input logic [31:0] base);
      csr_wr_en   <= 1'b1;
      csr_index   <= CSR_OVERRIDE_COUNT;
      csr_wr_data <= count_word;
      @(posedge clock);
      sb.write_reg(CSR_OVERRIDE_COUNT, count_word);
      csr_index   <= CSR_GSI_BASE;
      csr_wr_data <= base;
      @(posedge clock);
      sb.write_reg(CSR_GSI_BASE, base);
      csr_wr_en <= 1'b0;
   endtask

   initial begin
      int          phase;
      int          n;
      int          pick;
      int          gap;
      logic [4:0]  count;
      logic [31:0] count_word;
      logic [31:0] base_word;
      req_beat_t   b;

      sb = new();
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Empty table: identity mapping, including both ends of the index wrap.
      send_request(make_request(KIND_REMAP, 4'h0, 8'd0, 32'h0, 16'h0000, 8'h00, 1'b0));
      send_request(make_request(KIND_REMAP, 4'hF, 8'd255, 32'hFFFF_FFFF, 16'hFFFF,
                                8'hFF, 1'b1));
      send_request(make_request(KIND_REMAP, 4'h5, 8'd120, 32'h0, 16'h0000, 8'h5A, 1'b0));

      // Fill every slot so that no later search touches an unloaded entry.
      send_request(make_request(KIND_LOAD, 4'd0, 8'd0, 32'h0, 16'h0000, 8'h00, 1'b0));
      send_request(make_request(KIND_LOAD, 4'd1, 8'd11, 32'h21, 16'h0000, 8'h00, 1'b0));
      send_request(make_request(KIND_LOAD, 4'd2, 8'd255, 32'hFFFF_FFFF, 16'hFFFF,
                                8'hFF, 1'b1));
      send_request(make_request(KIND_LOAD, 4'd3, 8'd5, 32'h30, 16'h0002, 8'h00, 1'b0));
      // Duplicate source IRQ behind slot 3; the earlier entry must win.
      send_request(make_request(KIND_LOAD, 4'd4, 8'd5, 32'h40, 16'h0008, 8'h00, 1'b0));
      send_request(make_request(KIND_LOAD, 4'd5, 8'd9, 32'h77, 16'h000A, 8'h00, 1'b0));
      for (n = 6; n < 15; n++)
         send_request(make_request(KIND_LOAD, 4'(n), 8'(20 + n), $urandom(),
                                   16'($urandom_range(0, 65535)), 8'h00, 1'b0));
      send_request(make_request(KIND_LOAD, 4'd15, 8'd200, 32'h1234_5678, 16'hFFF5,
                                8'h00, 1'b0));

      // Full table search: hits, the forced-level IRQ, shadowing and misses.
      wait_idle();
      write_settings(32'd16, 32'd0);
      send_request(make_request(KIND_REMAP, 4'h0, 8'd0, 32'h0, 16'h0000, 8'h31, 1'b0));
      send_request(make_request(KIND_REMAP, 4'h0, 8'd11, 32'h0, 16'h0000, 8'hFF, 1'b1));
      send_request(make_request(KIND_REMAP, 4'h0, 8'd255, 32'h0, 16'h0000, 8'h80, 1'b0));
      send_request(make_request(KIND_REMAP, 4'h0, 8'd5, 32'h0, 16'h0000, 8'h41, 1'b0));
      send_request(make_request(KIND_REMAP, 4'h0, 8'd9, 32'h0, 16'h0000, 8'h42, 1'b1));
      send_request(make_request(KIND_REMAP, 4'h0, 8'd200, 32'h0, 16'h0000, 8'h43, 1'b0));
      send_request(make_request(KIND_REMAP, 4'h0, 8'd77, 32'h0, 16'h0000, 8'h44, 1'b0));
      send_request(make_request(KIND_REMAP, 4'h0, 8'd14, 32'h0, 16'h0000, 8'h45, 1'b1));

      // Random phases, each under its own register setting.
      for (phase = 0; phase < PHASES; phase++) begin
         wait_idle();
         case (phase)
            0: begin count = 5'd0;  base_word = 32'hFFFF_FFFF; end
            1: begin count = 5'd31; base_word = 32'hFFFF_FFFF; end
            2: begin count = 5'd16; base_word = 32'd0;         end
            3: begin count = 5'd1;  base_word = $urandom();    end
            4: begin count = 5'd17; base_word = 32'd0;         end
            5: begin count = 5'd15; base_word = $urandom();    end
            default: begin
               count = 5'($urandom_range(0, 31));
               case ($urandom_range(0, 3))
                  0: base_word = 32'd0;
                  1: base_word = 32'hFFFF_FFFF;
                  2: base_word = 32'($urandom_range(0, 64));
                  default: base_word = $urandom();
               endcase
            end
         endcase
         // Bits above the count field are don't-care and get random filler half the time.
         count_word = ($urandom_range(0, 1) == 1) ? {27'($urandom()), count}
                                                  : {27'd0, count};
         write_settings(count_word, base_word);

         for (n = 0; n < RANDOM_BEATS / PHASES; n++) begin
            b.kind        = ($urandom_range(0, 99) < 72) ? KIND_REMAP : KIND_LOAD;
            b.slot        = 4'($urandom_range(0, 15));
            b.entry_gsi   = $urandom();
            b.entry_flags = 16'($urandom_range(0, 65535));
            b.vector      = 8'($urandom_range(0, 255));
            b.masked      = 1'($urandom_range(0, 1));
            pick          = $urandom_range(0, 9);
            if (b.kind == KIND_LOAD) begin
               // Small IRQ pool so that duplicates and the forced-level IRQ show up.
               b.irq = (pick < 5) ? 8'($urandom_range(0, 15)) : 8'($urandom_range(0, 255));
               if (pick == 0) b.entry_gsi = sb.gsi_base + $urandom_range(0, 200);
            end else if (pick < 6) begin
               b.irq = sb.src_irq[$urandom_range(0, TABLE_DEPTH - 1)];
            end else if (pick == 6) begin
               b.irq = IRQ_FORCED_LEVEL;
            end else begin
               b.irq = 8'($urandom_range(0, 255));
            end
            send_request(b);

            pick = $urandom_range(0, 99);
            if (pick < 55) gap = 0;
            else if (pick < 92) gap = $urandom_range(1, 3);
            else gap = $urandom_range(8, 40);
            pause_requests(gap);
         end
      end

      wait_idle();
      if (sb.errors == 0) begin
         $display("irq_override_redirection_writer_unit verification clean");
      end else begin
         $display("irq_override_redirection_writer_unit verification failed");
      end
      $finish;
   end

endmodule
